// File: src/gnhr_pkg.sv
// Shared types and constants of the grid nearest-hit ray scorer.
// No dependencies; imported by the controller, datapath and top level.
package gnhr_pkg;

  localparam int COORD_W = 13;   // cell coordinate plus window offset, signed
  localparam int DIM_W   = 9;    // grid_width / grid_height registers
  localparam int WIN_W   = 3;    // window column / row counter, radius up to 2
  localparam int SCORE_W = 16;
  localparam int TOTAL_W = 25;
  localparam int DSQ_W   = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // register indexes on the configuration port
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // item operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCORE = 1'b1;

  typedef struct packed {
    logic             load;       // capture input beat, clear search state
    logic             mem_write;  // store the captured cell into the map
    logic             rd_issue;   // read one window cell
    logic [WIN_W-1:0] win_col;
    logic [WIN_W-1:0] win_row;
    logic             emit;       // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;               // result register empty or being taken
  } dp_status_t;

  // Q2.14 value of 1/distance by squared distance, 2.0 on a direct hit
  function automatic logic [SCORE_W-1:0] inv_dist(input logic [DSQ_W-1:0] d2);
    logic [SCORE_W-1:0] v;
    unique case (d2)
      4'd0:    v = 16'd32768;
      4'd1:    v = 16'd16384;
      4'd2:    v = 16'd11585;
      4'd4:    v = 16'd8192;
      4'd5:    v = 16'd7327;
      4'd8:    v = 16'd5793;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/grid_nearest_hit_ray_scorer.sv
// Top level of the grid nearest-hit ray scorer: controller plus datapath.
// Depends on gnhr_pkg, gnhr_ctrl, gnhr_datapath (and through it gnhr_ram).
//
//   channel  handshake             payload
//   -------  --------------------  ---------------------------------------------
//   cfg      cfg_valid/cfg_ready   cfg_index (0 grid_width, 1 grid_height), cfg_data
//   in       in_valid/in_ready     op, cell_x, cell_y, log_odds, last_ray
//   out      out_valid/out_ready   ray_score, hit_found, hit_dist_sq, scan_total,
//                                  scan_done
//
// One beat in, one beat out. A write beat passes the write step, then the
// result step. A score beat walks the window one cell a cycle through the
// single read port of the map, then passes the drain and result steps.
// The next input beat is taken as soon as the result register is loaded, even
// while that result still waits on out_ready; a stalled output holds the block
// in its result step. Synchronous reset clears control state, the scan total
// and sets both grid dimensions to 256; the map itself is not cleared.
module grid_nearest_hit_ray_scorer import gnhr_pkg::*; #(
  parameter int GRID_SIDE     = 256,
  parameter int SEARCH_RADIUS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic signed [11:0]   cell_x,
  input  logic signed [11:0]   cell_y,
  input  logic signed [7:0]    log_odds,
  input  logic                 last_ray,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SCORE_W-1:0]   ray_score,
  output logic                 hit_found,
  output logic [DSQ_W-1:0]     hit_dist_sq,
  output logic [TOTAL_W-1:0]   scan_total,
  output logic                 scan_done
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: accepts beats, steps the window counters, times the result load
  gnhr_ctrl #(
    .SEARCH_RADIUS (SEARCH_RADIUS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  // map, nearest-hit search, accumulator and output register
  gnhr_datapath #(
    .GRID_SIDE     (GRID_SIDE),
    .SEARCH_RADIUS (SEARCH_RADIUS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .op          (op),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .log_odds    (log_odds),
    .last_ray    (last_ray),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ray_score   (ray_score),
    .hit_found   (hit_found),
    .hit_dist_sq (hit_dist_sq),
    .scan_total  (scan_total),
    .scan_done   (scan_done)
  );

endmodule

// File: src/gnhr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnhr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/gnhr_ctrl.sv
// Controller state machine of the ray scorer: input handshake, window walk.
// Depends on gnhr_pkg for the command and status structs.
module gnhr_ctrl import gnhr_pkg::*; #(
  parameter int SEARCH_RADIUS = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(2 * SEARCH_RADIUS);

  logic [2:0]       state, state_next;
  logic [WIN_W-1:0] col, col_next;
  logic [WIN_W-1:0] row, row_next;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    unique case (state)
      S_IDLE: begin
        col_next = '0;
        row_next = '0;
        if (accept) begin
          state_next = (op == OP_SCORE) ? S_SCAN : S_WRITE;
        end
      end
      S_WRITE: state_next = S_RESULT;
      S_SCAN: begin
        if (col == WIN_LAST) begin
          col_next = '0;
          row_next = row + 1'b1;
          if (row == WIN_LAST) begin
            state_next = S_DRAIN;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      S_DRAIN: state_next = S_RESULT;
      S_RESULT: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.mem_write = (state == S_WRITE);
    cmd.rd_issue  = (state == S_SCAN);
    cmd.win_col   = col;
    cmd.win_row   = row;
    cmd.emit      = (state == S_RESULT) && status.out_free;
  end

endmodule

// File: src/gnhr_datapath.sv
// Datapath of the ray scorer: item and config registers, occupancy map,
// nearest-hit tracking, score accumulation and result register.
// Depends on gnhr_pkg and gnhr_ram.
module gnhr_datapath import gnhr_pkg::*; #(
  parameter int GRID_SIDE     = 256,
  parameter int SEARCH_RADIUS = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [DIM_W-1:0]          cfg_data,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic                      op,
  input  logic signed [11:0]        cell_x,
  input  logic signed [11:0]        cell_y,
  input  logic signed [7:0]         log_odds,
  input  logic                      last_ray,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SCORE_W-1:0]        ray_score,
  output logic                      hit_found,
  output logic [DSQ_W-1:0]          hit_dist_sq,
  output logic [TOTAL_W-1:0]        scan_total,
  output logic                      scan_done
);

  localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int U_W    = COORD_W - 1;
  localparam logic [WIN_W-1:0] RAD = WIN_W'(SEARCH_RADIUS);

  logic [DIM_W-1:0] grid_width, grid_height;

  logic                      item_op;
  logic signed [COORD_W-1:0] item_x, item_y;
  logic                      item_occ;
  logic                      item_last;

  logic                      rd_pend, rd_inb;
  logic [DSQ_W-1:0]          rd_d2;
  logic                      best_found;
  logic [DSQ_W-1:0]          best_d2;
  logic [TOTAL_W-1:0]        acc;

  logic signed [COORD_W-1:0] nx, ny;
  logic [WIN_W-1:0]          dxa, dya;
  logic [DSQ_W-1:0]          ax, ay, d2;
  logic                      wr_en, win_inb;
  logic [ADDR_W-1:0]         wr_addr, rd_addr;
  logic                      mem_q;
  logic [SCORE_W-1:0]        score;
  logic [TOTAL_W:0]          sum;
  logic [TOTAL_W-1:0]        total;

  function automatic logic in_grid(input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y,
                                   input logic [DIM_W-1:0] w,
                                   input logic [DIM_W-1:0] h);
    logic [U_W-1:0] xu, yu;
    xu = x[U_W-1:0];
    yu = y[U_W-1:0];
    return !x[COORD_W-1] && !y[COORD_W-1] &&
           (xu < U_W'(w)) && (yu < U_W'(h)) &&
           ({1'b0, xu} < COORD_W'(GRID_SIDE)) && ({1'b0, yu} < COORD_W'(GRID_SIDE));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_W-1:0] x,
                                                  input logic signed [COORD_W-1:0] y);
    logic [U_W-1:0] xu, yu;
    xu = x[U_W-1:0];
    yu = y[U_W-1:0];
    return ADDR_W'(yu) * ADDR_W'(GRID_SIDE) + ADDR_W'(xu);
  endfunction

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(256);
      grid_height <= DIM_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op   <= op;
      item_x    <= COORD_W'(cell_x);
      item_y    <= COORD_W'(cell_y);
      item_occ  <= (log_odds > 8'sd0);
      item_last <= last_ray;
    end
  end

  // window cell under the current counters
  always_comb begin
    nx  = item_x + COORD_W'(cmd.win_col) - COORD_W'(SEARCH_RADIUS);
    ny  = item_y + COORD_W'(cmd.win_row) - COORD_W'(SEARCH_RADIUS);
    dxa = (cmd.win_col >= RAD) ? cmd.win_col - RAD : RAD - cmd.win_col;
    dya = (cmd.win_row >= RAD) ? cmd.win_row - RAD : RAD - cmd.win_row;
    ax  = DSQ_W'(dxa);
    ay  = DSQ_W'(dya);
    d2  = ax * ax + ay * ay;
  end

  assign win_inb = in_grid(nx, ny, grid_width, grid_height);
  assign rd_addr = cell_addr(nx, ny);
  assign wr_en   = cmd.mem_write && in_grid(item_x, item_y, grid_width, grid_height);
  assign wr_addr = cell_addr(item_x, item_y);

  gnhr_ram #(
    .WIDTH (1),
    .DEPTH (GRID_SIDE * GRID_SIDE)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item_occ),
    .re    (cmd.rd_issue && win_inb),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  // read tag registered in step with the map read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
    end
    rd_inb <= win_inb;
    rd_d2  <= d2;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_found <= 1'b0;
      best_d2    <= '0;
    end else if (rd_pend && rd_inb && mem_q && (!best_found || rd_d2 < best_d2)) begin
      best_found <= 1'b1;
      best_d2    <= rd_d2;
    end
  end

  // score and saturating scan total
  always_comb begin
    score = (item_op == OP_SCORE && best_found) ? inv_dist(best_d2) : '0;
    sum   = {1'b0, acc} + (TOTAL_W + 1)'(score);
    total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.emit && item_op == OP_SCORE) begin
      acc <= item_last ? '0 : total;
    end
  end

  // result register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ray_score <= score;
      if (item_op == OP_SCORE) begin
        hit_found   <= best_found;
        hit_dist_sq <= best_found ? best_d2 : '0;
        scan_total  <= total;
        scan_done   <= item_last;
      end else begin
        hit_found   <= 1'b0;
        hit_dist_sq <= '0;
        scan_total  <= acc;
        scan_done   <= 1'b0;
      end
    end
  end

endmodule

// File: sim/grid_nearest_hit_ray_scorer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_nearest_hit_ray_scorer: map writes, ray scoring, scan totals.
// Depends on gnhr_pkg and the RTL of the block; a scoreboard class predicts every result beat.

module grid_nearest_hit_ray_scorer_tb;
  import gnhr_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 32;    // settle time once every result is back
  localparam int SAT_RAYS     = 1030;  // 1024 direct hits are enough to saturate

  // one result beat, field for field
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               found;
    logic [DSQ_W-1:0]   dsq;
    logic [TOTAL_W-1:0] total;
    logic               done;
  } ray_result_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of the map, the scan total and both grid registers.
  // Each accepted input beat produces exactly one expected result.
  // ---------------------------------------------------------------------------
  class hit_scorer_model_t;
    localparam int SIDE  = 256;
    localparam int REACH = 2;

    bit                 occupied [SIDE*SIDE];
    bit                 written  [SIDE*SIDE];  // cells the stimulus has stored
    logic [TOTAL_W-1:0] scan_sum;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    ray_result_t        pending[$];
    int                 mismatches;

    function new();
      scan_sum   = '0;
      width_reg  = 9'd256;
      height_reg = 9'd256;
      mismatches = 0;
    endfunction

    // register values above the store act as the full side
    function int eff_w();
      return (width_reg > SIDE) ? SIDE : int'(width_reg);
    endfunction

    function int eff_h();
      return (height_reg > SIDE) ? SIDE : int'(height_reg);
    endfunction

    function bit on_map(int x, int y);
      return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
    endfunction

    function bit needs_write(int x, int y);
      return on_map(x, y) && !written[y*SIDE + x];
    endfunction

    function void set_reg(logic idx, logic [DIM_W-1:0] v);
      if (idx == REG_GRID_WIDTH) width_reg = v;
      else                       height_reg = v;
    endfunction

    function logic [SCORE_W-1:0] inverse_distance(int d2);
      case (d2)
        0:       return 16'd32768;
        1:       return 16'd16384;
        2:       return 16'd11585;
        4:       return 16'd8192;
        5:       return 16'd7327;
        8:       return 16'd5793;
        default: return 16'd0;
      endcase
    endfunction

    function void take_item(logic op_i, logic signed [11:0] x, logic signed [11:0] y,
                            logic signed [7:0] lo, logic last);
      ray_result_t      r;
      int               cx, cy, nx, ny, d2, best;
      bit               found;
      logic [TOTAL_W:0] sum;
      r     = '0;
      cx    = int'(x);
      cy    = int'(y);
      found = 1'b0;
      best  = 0;
      if (op_i == OP_WRITE) begin
        // off-map writes are dropped; the beat still returns the running total
        if (on_map(cx, cy)) begin
          occupied[cy*SIDE + cx] = (lo > 0);
          written[cy*SIDE + cx]  = 1'b1;
        end
        r.total = scan_sum;
      end else begin
        for (int dy = -REACH; dy <= REACH; dy++) begin
          for (int dx = -REACH; dx <= REACH; dx++) begin
            nx = cx + dx;
            ny = cy + dy;
            d2 = dx*dx + dy*dy;
            if (on_map(nx, ny) && occupied[ny*SIDE + nx] && (!found || d2 < best)) begin
              found = 1'b1;
              best  = d2;
            end
          end
        end
        if (found) r.score = inverse_distance(best);
        r.found = found;
        r.dsq   = best[DSQ_W-1:0];
        sum = {1'b0, scan_sum} + (TOTAL_W + 1)'(r.score);
        if (sum > {1'b0, TOTAL_MAX}) sum = {1'b0, TOTAL_MAX};
        r.total = sum[TOTAL_W-1:0];
        if (last) begin
          r.done   = 1'b1;
          scan_sum = '0;
        end else begin
          scan_sum = sum[TOTAL_W-1:0];
        end
      end
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(ray_result_t got);
      ray_result_t want;
      if (pending.size() == 0) begin
        report("result beat with no item outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.score !== want.score)
        report($sformatf("ray_score %0d, expected %0d", got.score, want.score));
      if (got.found !== want.found)
        report($sformatf("hit_found %0b, expected %0b", got.found, want.found));
      if (got.dsq !== want.dsq)
        report($sformatf("hit_dist_sq %0d, expected %0d", got.dsq, want.dsq));
      if (got.total !== want.total)
        report($sformatf("scan_total %0d, expected %0d", got.total, want.total));
      if (got.done !== want.done)
        report($sformatf("scan_done %0b, expected %0b", got.done, want.done));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Block under test. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_index = REG_GRID_WIDTH;
  logic [DIM_W-1:0]    cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                op        = OP_WRITE;
  logic signed [11:0]  cell_x    = '0;
  logic signed [11:0]  cell_y    = '0;
  logic signed [7:0]   log_odds  = '0;
  logic                last_ray  = 1'b0;
  logic                out_ready = 1'b0;
  logic                cfg_ready, in_ready, out_valid, hit_found, scan_done;
  logic [SCORE_W-1:0]  ray_score;
  logic [DSQ_W-1:0]    hit_dist_sq;
  logic [TOTAL_W-1:0]  scan_total;

  grid_nearest_hit_ray_scorer uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .cell_x(cell_x), .cell_y(cell_y),
    .log_odds(log_odds), .last_ray(last_ray),
    .out_valid(out_valid), .out_ready(out_ready), .ray_score(ray_score),
    .hit_found(hit_found), .hit_dist_sq(hit_dist_sq), .scan_total(scan_total),
    .scan_done(scan_done)
  );

  hit_scorer_model_t sb = new();
  int sent         = 0;   // input beats accepted so far
  int quiet_cycles = 0;
  bit calm         = 0;   // when set, neither side idles

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Output side: a fresh random stall before each result beat, none while calm.
  // Results are checked at the edge where valid and ready are both high.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = calm ? 0 : int'($urandom_range(0, 8));
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{score: ray_score, found: hit_found, dsq: hit_dist_sq,
                        total: scan_total, done: scan_done});
  end

  // Watchdog: any beat on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("grid_nearest_hit_ray_scorer_tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Valid stays up across back-to-back beats; it is only dropped
  // when a gap is drawn or in a drain, so in_valid never sees two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic o, input logic signed [11:0] x,
                           input logic signed [11:0] y, input logic signed [7:0] lo,
                           input logic last);
    int gap;
    if ($urandom_range(0, 49) == 0) calm = !calm;
    gap = calm ? 0 : int'($urandom_range(0, 8));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    cell_x   <= x;
    cell_y   <= y;
    log_odds <= lo;
    last_ray <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_item(o, x, y, lo, last);
    sent++;
  endtask

  // mostly free cells, so that the nearest hit often lies off centre
  function automatic logic signed [7:0] draw_log_odds();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 127));
    return 8'(-int'($urandom_range(0, 128)));
  endfunction

  // A score must never read a cell that was never stored: write any in-grid
  // cell of the window that is still blank before the ray goes in.
  task automatic fill_window(input int cx, input int cy);
    for (int dy = -2; dy <= 2; dy++)
      for (int dx = -2; dx <= 2; dx++)
        if (sb.needs_write(cx + dx, cy + dy))
          send_beat(OP_WRITE, 12'(cx + dx), 12'(cy + dy), draw_log_odds(),
                    1'($urandom_range(0, 1)));
  endtask

  task automatic score_ray(input int cx, input int cy, input logic last);
    fill_window(cx, cy);
    send_beat(OP_SCORE, 12'(cx), 12'(cy), 8'($urandom), last);
  endtask

  // Cells cluster near the origin corner or the far corner of the grid in
  // use, straddling its borders so windows get clipped on every side.
  function automatic void pick_cell(output int cx, output int cy);
    int span_x, span_y;
    if ($urandom_range(0, 3) == 0 && sb.eff_w() > 0 && sb.eff_h() > 0) begin
      cx = sb.eff_w() - 4 + int'($urandom_range(0, 6));
      cy = sb.eff_h() - 4 + int'($urandom_range(0, 6));
    end else begin
      span_x = (sb.eff_w() == 0) ? 4 : ((sb.eff_w() < 12) ? sb.eff_w() : 12);
      span_y = (sb.eff_h() == 0) ? 4 : ((sb.eff_h() < 12) ? sb.eff_h() : 12);
      cx = int'($urandom_range(0, span_x + 5)) - 3;
      cy = int'($urandom_range(0, span_y + 5)) - 3;
    end
  endfunction

  // Random traffic: scores with window fill, map rewrites, and a share of
  // noise beats with full-range fields (mostly far off the map).
  task automatic random_phase(input int beats);
    int                 stop, pick, cx, cy;
    logic signed [11:0] rx, ry;
    stop = sent + beats;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pick_cell(cx, cy);
        score_ray(cx, cy, $urandom_range(0, 9) == 0);
      end else if (pick < 85) begin
        pick_cell(cx, cy);
        send_beat(OP_WRITE, 12'(cx), 12'(cy), draw_log_odds(), 1'($urandom_range(0, 1)));
      end else begin
        rx = 12'($urandom);
        ry = 12'($urandom);
        if ($urandom_range(0, 1) == 1)
          score_ray(int'(rx), int'(ry), 1'($urandom_range(0, 1)));
        else
          send_beat(OP_WRITE, rx, ry, 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Let every outstanding result come back, then allow the block to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both grid registers in back-to-back beats; valid held across the pair.
  task automatic write_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(REG_GRID_WIDTH, w);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(REG_GRID_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Grid settings per phase; -1 draws a random 9-bit value.
  // 0 leaves no cell on the map, 257 and 511 clamp to the full side.
  int phase_w[7]   = '{256, 1, 0, 511, 5, -1, 255};
  int phase_h[7]   = '{256, 1, 7, 257, 256, -1, 2};
  int phase_len[7] = '{90, 60, 40, 90, 80, 110, 100};

  initial begin
    int w, h;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset grid of 256 x 256 ---
    // blank 3x3 corner around the origin, all stored free (last flag ignored)
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        send_beat(OP_WRITE, 12'(x), 12'(y),
                  ((x + y) % 3 == 0) ? 8'h00 : (((x + y) % 3 == 1) ? 8'hFF : 8'h80),
                  x == 2);
    send_beat(OP_SCORE, 12'sd0, 12'sd0, 8'sd0, 1'b0);      // nothing in the window
    // each new occupied cell sits nearer, walking the whole distance table
    send_beat(OP_WRITE, 12'sd2, 12'sd2, 8'sd1, 1'b0);
    send_beat(OP_SCORE, 12'sd0, 12'sd0, 8'sd0, 1'b0);      // d^2 = 8
    send_beat(OP_WRITE, 12'sd1, 12'sd2, 8'sd127, 1'b0);
    send_beat(OP_SCORE, 12'sd0, 12'sd0, 8'sd5, 1'b0);      // d^2 = 5
    send_beat(OP_WRITE, 12'sd2, 12'sd0, 8'sd64, 1'b0);
    send_beat(OP_SCORE, 12'sd0, 12'sd0, 8'sd0, 1'b0);      // d^2 = 4
    send_beat(OP_WRITE, 12'sd1, 12'sd1, 8'sd100, 1'b0);
    send_beat(OP_SCORE, 12'sd0, 12'sd0, 8'sd0, 1'b0);      // d^2 = 2
    send_beat(OP_WRITE, 12'sd0, 12'sd1, 8'sd2, 1'b0);
    send_beat(OP_SCORE, 12'sd0, 12'sd0, 8'sd0, 1'b0);      // d^2 = 1
    send_beat(OP_WRITE, 12'sd0, 12'sd0, 8'sd127, 1'b1);
    send_beat(OP_SCORE, 12'sd0, 12'sd0, 8'h80, 1'b1);      // direct hit, closes scan
    // off-map writes are dropped; a far-away ray finds nothing but still closes
    send_beat(OP_WRITE, -12'sd1, -12'sd1, 8'sd127, 1'b0);
    send_beat(OP_WRITE, 12'h7FF, 12'h800, 8'sd127, 1'b0);
    send_beat(OP_SCORE, 12'h800, 12'h7FF, 8'sd0, 1'b1);

    // --- long scan of direct hits: the total must pin at its ceiling ---
    fill_window(100, 100);
    send_beat(OP_WRITE, 12'sd100, 12'sd100, 8'sd127, 1'b0);
    repeat (SAT_RAYS) send_beat(OP_SCORE, 12'sd100, 12'sd100, 8'($urandom), 1'b0);
    send_beat(OP_SCORE, 12'sd100, 12'sd100, 8'($urandom), 1'b1);

    // --- random phases, grid registers changed only while the block is idle ---
    for (int p = 0; p < 7; p++) begin
      drain();
      w = (phase_w[p] < 0) ? int'($urandom_range(0, 511)) : phase_w[p];
      h = (phase_h[p] < 0) ? int'($urandom_range(0, 511)) : phase_h[p];
      write_regs(9'(w), 9'(h));
      random_phase(phase_len[p]);
    end

    drain();
    if (sb.mismatches == 0)
      $display("grid_nearest_hit_ray_scorer_tb: done, clean");
    else
      $display("grid_nearest_hit_ray_scorer_tb: done, errors");
    $finish;
  end

endmodule

// File: grid_nearest_hit_ray_scorer.f
src/gnhr_pkg.sv
src/gnhr_ram.sv
src/gnhr_ctrl.sv
src/gnhr_datapath.sv
src/grid_nearest_hit_ray_scorer.sv
sim/grid_nearest_hit_ray_scorer_tb.sv
